[rtl/qs_pkg.sv]
package qs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STACK_DEPTH = 64;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int STK_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TOP_W   = STK_W + 1;
    localparam int ENTRY_W = 2 * IDX_W;

    localparam int ST_W = 4;

    localparam logic [ST_W-1:0] S_LOAD  = 4'd0;
    localparam logic [ST_W-1:0] S_POP   = 4'd1;
    localparam logic [ST_W-1:0] S_POPW  = 4'd2;
    localparam logic [ST_W-1:0] S_PIVW  = 4'd3;
    localparam logic [ST_W-1:0] S_RSCAN = 4'd4;
    localparam logic [ST_W-1:0] S_LSCAN = 4'd5;
    localparam logic [ST_W-1:0] S_FIN   = 4'd6;
    localparam logic [ST_W-1:0] S_PUSH2 = 4'd7;
    localparam logic [ST_W-1:0] S_OUTW  = 4'd8;
    localparam logic [ST_W-1:0] S_OUTH  = 4'd9;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [TOP_W-1:0]   top_t;
    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

[rtl/qs_ram.sv]
module qs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/quicksort_sorter.sv]
// quicksort_sorter: collects a set of signed 32-bit words and returns them in
// ascending order.
// input channel s_*: one word per handshake, s_tdata holds the value, s_tlast
// marks the final word of the set. up to MAX_ITEMS words are kept; any further
// word of the set is dropped and the whole set is flagged on m_tuser.
// output channel m_*: the sorted set, m_tlast on its final word, m_tuser set
// on every word of a set that lost words.
// while loading, s_tready is high and one word is taken per cycle.
// after the word with s_tlast, s_tready stays low until the last sorted word
// has been taken. sorting runs from a 64-entry single-port-read element
// memory and a range stack memory, both with registered reads.
// a partition pops its range, reads the stack entry and the pivot, compares
// the other words against the pivot (a swap shares its compare step), places
// the pivot and pushes up to two ranges, the second in a state of its own.
// each sorted word is read from the element memory and then held on the
// output until it is taken.
// while m_tready is low the current output word is held and sorting work
// is already complete; the block waits.
// reset (rst_n low, asynchronous) empties the block: no words held, no flag.
module quicksort_sorter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sorted_value[31:0]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // overflow[0]
);

    logic [qs_pkg::ST_W-1:0]   state_reg, state_next;
    qs_pkg::cnt_t              count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    qs_pkg::top_t              top_reg, top_next;
    qs_pkg::idx_t              left_reg, left_next;
    qs_pkg::idx_t              right_reg, right_next;
    qs_pkg::idx_t              piv_reg, piv_next;
    qs_pkg::idx_t              lo_reg, lo_next;
    qs_pkg::idx_t              hi_reg, hi_next;
    logic [qs_pkg::DATA_W-1:0] pval_reg, pval_next;
    qs_pkg::cnt_t              k_reg, k_next;
    logic                      out_valid_reg, out_valid_next;
    logic [qs_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;
    logic                      fwd_hit_reg, fwd_hit_next;
    logic [qs_pkg::DATA_W-1:0] fwd_data_reg, fwd_data_next;

    logic                      store_we;
    qs_pkg::idx_t              store_waddr, store_raddr;
    logic [qs_pkg::DATA_W-1:0] store_wdata, store_rdata, sdata;

    logic                        stk_we;
    logic [qs_pkg::STK_W-1:0]    stk_waddr, stk_raddr;
    qs_pkg::entry_t              stk_wdata, stk_rdata;

    qs_pkg::cnt_t n_eff;
    qs_pkg::idx_t scan_step;
    logic         push_lo, push_hi, stk_room;

    qs_ram #(.WIDTH(qs_pkg::DATA_W), .DEPTH(qs_pkg::MAX_ITEMS)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    qs_ram #(.WIDTH(qs_pkg::ENTRY_W), .DEPTH(qs_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // write-to-read forwarding on the element memory
    assign sdata = fwd_hit_reg ? fwd_data_reg : store_rdata;

    assign s_tready = (state_reg == qs_pkg::S_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    assign n_eff = (count_reg < qs_pkg::CNT_W'(qs_pkg::MAX_ITEMS))
                   ? count_reg + qs_pkg::CNT_W'(1) : count_reg;
    assign push_lo  = ({1'b0, piv_reg} >= ({1'b0, lo_reg} + qs_pkg::CNT_W'(2)));
    assign push_hi  = (({1'b0, piv_reg} + qs_pkg::CNT_W'(1)) < {1'b0, hi_reg});
    assign stk_room = (top_reg < qs_pkg::TOP_W'(qs_pkg::STACK_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        piv_next       = piv_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pval_next      = pval_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        store_we       = 1'b0;
        store_waddr    = piv_reg;
        store_wdata    = sdata;
        store_raddr    = '0;
        stk_we         = 1'b0;
        stk_waddr      = top_reg[qs_pkg::STK_W-1:0];
        stk_wdata      = {lo_reg, piv_reg - qs_pkg::IDX_W'(1)};
        stk_raddr      = '0;
        scan_step      = '0;

        case (state_reg)
            qs_pkg::S_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < qs_pkg::CNT_W'(qs_pkg::MAX_ITEMS))
                    begin
                        store_we    = 1'b1;
                        store_waddr = count_reg[qs_pkg::IDX_W-1:0];
                        store_wdata = s_tdata;
                        count_next  = count_reg + qs_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        if (n_eff > qs_pkg::CNT_W'(1))
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = {qs_pkg::IDX_W'(0),
                                         qs_pkg::IDX_W'(n_eff - qs_pkg::CNT_W'(1))};
                            top_next  = qs_pkg::TOP_W'(1);
                        end
                        state_next = qs_pkg::S_POP;
                    end
                end
            end
            qs_pkg::S_POP:
            begin
                if (top_reg == '0)
                begin
                    store_raddr = '0;
                    k_next      = '0;
                    state_next  = qs_pkg::S_OUTW;
                end
                else
                begin
                    top_next   = top_reg - qs_pkg::TOP_W'(1);
                    stk_raddr  = top_next[qs_pkg::STK_W-1:0];
                    state_next = qs_pkg::S_POPW;
                end
            end
            qs_pkg::S_POPW:
            begin
                lo_next     = stk_rdata[qs_pkg::ENTRY_W-1:qs_pkg::IDX_W];
                hi_next     = stk_rdata[qs_pkg::IDX_W-1:0];
                left_next   = lo_next;
                right_next  = hi_next;
                piv_next    = lo_next;
                store_raddr = lo_next;
                state_next  = qs_pkg::S_PIVW;
            end
            qs_pkg::S_PIVW:
            begin
                pval_next = sdata;
                if (piv_reg == right_reg)
                begin
                    state_next = qs_pkg::S_FIN;
                end
                else
                begin
                    store_raddr = right_reg;
                    state_next  = qs_pkg::S_RSCAN;
                end
            end
            qs_pkg::S_RSCAN:
            begin
                if ($signed(sdata) >= $signed(pval_reg))
                begin
                    scan_step   = right_reg - qs_pkg::IDX_W'(1);
                    right_next  = scan_step;
                    store_raddr = scan_step;
                    if (scan_step == piv_reg)
                    begin
                        state_next = qs_pkg::S_FIN;
                    end
                end
                else
                begin
                    store_we    = 1'b1;
                    store_waddr = piv_reg;
                    store_wdata = sdata;
                    piv_next    = right_reg;
                    store_raddr = left_reg;
                    state_next  = (left_reg == right_reg) ? qs_pkg::S_FIN
                                                          : qs_pkg::S_LSCAN;
                end
            end
            qs_pkg::S_LSCAN:
            begin
                if ($signed(pval_reg) >= $signed(sdata))
                begin
                    scan_step   = left_reg + qs_pkg::IDX_W'(1);
                    left_next   = scan_step;
                    store_raddr = scan_step;
                    if (scan_step == piv_reg)
                    begin
                        state_next = qs_pkg::S_FIN;
                    end
                end
                else
                begin
                    store_we    = 1'b1;
                    store_waddr = piv_reg;
                    store_wdata = sdata;
                    piv_next    = left_reg;
                    store_raddr = right_reg;
                    state_next  = (left_reg == right_reg) ? qs_pkg::S_FIN
                                                          : qs_pkg::S_RSCAN;
                end
            end
            qs_pkg::S_FIN:
            begin
                // pivot lands in its final slot
                store_we    = 1'b1;
                store_waddr = piv_reg;
                store_wdata = pval_reg;
                state_next  = qs_pkg::S_POP;
                if (push_lo)
                begin
                    stk_we    = stk_room;
                    stk_wdata = {lo_reg, piv_reg - qs_pkg::IDX_W'(1)};
                    if (stk_room)
                    begin
                        top_next = top_reg + qs_pkg::TOP_W'(1);
                    end
                    if (push_hi)
                    begin
                        state_next = qs_pkg::S_PUSH2;
                    end
                end
                else if (push_hi)
                begin
                    stk_we    = stk_room;
                    stk_wdata = {piv_reg + qs_pkg::IDX_W'(1), hi_reg};
                    if (stk_room)
                    begin
                        top_next = top_reg + qs_pkg::TOP_W'(1);
                    end
                end
            end
            qs_pkg::S_PUSH2:
            begin
                stk_we    = stk_room;
                stk_wdata = {piv_reg + qs_pkg::IDX_W'(1), hi_reg};
                if (stk_room)
                begin
                    top_next = top_reg + qs_pkg::TOP_W'(1);
                end
                state_next = qs_pkg::S_POP;
            end
            qs_pkg::S_OUTW:
            begin
                out_valid_next = 1'b1;
                out_data_next  = sdata;
                out_last_next  = ((k_reg + qs_pkg::CNT_W'(1)) == count_reg);
                out_ovf_next   = ovf_reg;
                state_next     = qs_pkg::S_OUTH;
            end
            qs_pkg::S_OUTH:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = qs_pkg::S_LOAD;
                    end
                    else
                    begin
                        k_next      = k_reg + qs_pkg::CNT_W'(1);
                        store_raddr = k_next[qs_pkg::IDX_W-1:0];
                        state_next  = qs_pkg::S_OUTW;
                    end
                end
            end
            default:
            begin
                state_next = qs_pkg::S_LOAD;
            end
        endcase
    end

    assign fwd_hit_next  = store_we && (store_waddr == store_raddr);
    assign fwd_data_next = store_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qs_pkg::S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            top_reg       <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            piv_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            top_reg       <= top_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            piv_reg       <= piv_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pval_reg     <= pval_next;
        out_data_reg <= out_data_next;
        fwd_data_reg <= fwd_data_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input open while output word pending");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= qs_pkg::TOP_W'(qs_pkg::STACK_DEPTH))
        else $error("range stack overrun");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= qs_pkg::CNT_W'(qs_pkg::MAX_ITEMS))
        else $error("element count overrun");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qs_pkg::S_RSCAN || state_reg == qs_pkg::S_LSCAN)
        |-> (left_reg <= piv_reg && piv_reg <= right_reg))
        else $error("scan pointers crossed the pivot");

    a_out_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (top_reg == '0))
        else $error("output started with ranges pending");
`endif

endmodule
